>>> design/vwa_pkg.sv
// Package for the VWAP window accumulator: request and response payload
// structs, controller command and status structs, and shared codes.
// No dependencies.
package vwa_pkg;

   typedef struct packed {
      logic        first_of_run;
      logic        last_of_trades;
      logic [46:0] trade_time;
      logic [30:0] trade_price;
      logic [23:0] trade_qty;
      logic        volume_eligible;
      logic        avg_px_eligible;
      logic        is_block;
      logic [7:0]  venue_code;
   } req_type;

   typedef struct packed {
      logic [31:0] window_count;
      logic [47:0] total_volume;
      logic [30:0] vwap_price;
      logic        notional_overflow;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic update;
      logic div_start;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic div_busy;
   } status_type;

   localparam logic [2:0] REG_WINDOW_MODE  = 3'd0;
   localparam logic [2:0] REG_SIDE         = 3'd1;
   localparam logic [2:0] REG_FLAVOR       = 3'd2;
   localparam logic [2:0] REG_LIMIT_ENABLE = 3'd3;
   localparam logic [2:0] REG_LIMIT_PRICE  = 3'd4;
   localparam logic [2:0] REG_START_TIME   = 3'd5;
   localparam logic [2:0] REG_END_TIME     = 3'd6;
   localparam logic [2:0] REG_TARGET       = 3'd7;

   localparam logic [1:0] MODE_TIME      = 2'd0;
   localparam logic [1:0] MODE_VOLUME    = 2'd1;
   localparam logic [1:0] MODE_TICKS_FWD = 2'd2;
   localparam logic [1:0] MODE_TICKS_REV = 2'd3;

   localparam logic [1:0] SIDE_BUY  = 2'd0;
   localparam logic [1:0] SIDE_SELL = 2'd1;

   localparam logic [2:0] FLV_ELIGIBLE = 3'd0;
   localparam logic [2:0] FLV_REGULAR  = 3'd1;
   localparam logic [2:0] FLV_EXCHANGE = 3'd2;
   localparam logic [2:0] FLV_BLOCK    = 3'd3;
   localparam logic [2:0] FLV_OFFEX    = 3'd4;

   localparam logic [7:0] CHAR_OFFEX = 8'h44;

   localparam int DIV_STEPS     = 64;
   localparam int DIV_STEP_BITS = 6;

endpackage

>>> design/vwap_window_accumulator.sv
// VWAP window accumulator, top level. Depends on vwa_pkg, vwa_controller, vwa_datapath.
// A request that gives no response passes the evaluate and update states; the next request
// is accepted once the controller is back in idle. A request that closes the window also
// passes the start, divide and load states; the bit-serial divider yields one quotient bit per
// cycle. A pending response waits in an output register while the next request is accepted.
// Synchronous reset clears the configuration to zero, closes the window, drops any response.
module vwap_window_accumulator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vwa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vwa_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [46:0]      csr_data
);
   import vwa_pkg::*;

   cmd_type    cmd;
   status_type status;

   vwa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vwa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.eval, cmd.update, cmd.div_start, cmd.load_rsp}))
      else $error("More than one command is active.");

   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("Divider did not start.");

   a_no_req_while_div: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> req_stall)
      else $error("Request channel open while the divider runs.");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("Loaded response is not presented.");

endmodule

>>> design/vwa_divider.sv
// Bit-serial restoring divider: 64-bit notional by 48-bit volume,
// one quotient bit per cycle. Depends on vwa_pkg.
module vwa_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   import vwa_pkg::*;

   logic                     busy_ff, busy_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [47:0]              rem_ff, rem_in;
   logic [63:0]              quo_ff, quo_in;
   logic [48:0]              trial;
   logic [48:0]              diff;
   logic                     ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[63]};
      ge      = trial >= {1'b0, divisor};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_STEP_BITS'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[47:0] : trial[47:0];
         quo_in  = {quo_ff[62:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> design/vwa_datapath.sv
// Datapath: configuration registers, trade filter, window decision,
// multiply-accumulate, divider and response register.
// Depends on vwa_pkg and vwa_divider.
module vwa_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [46:0]         csr_data,
   input  vwa_pkg::req_type    req_data,
   input  vwa_pkg::cmd_type    cmd,
   output vwa_pkg::status_type status,
   output vwa_pkg::rsp_type    rsp_data
);
   import vwa_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  side_ff, side_in;
   logic [2:0]  flavor_ff, flavor_in;
   logic        limit_en_ff, limit_en_in;
   logic [30:0] limit_price_ff, limit_price_in;
   logic [46:0] start_ff, start_in;
   logic [46:0] end_ff, end_in;
   logic [39:0] target_ff, target_in;

   req_type     trade_ff, trade_in;
   logic        open_ff, open_in;
   logic [40:0] rem_ff, rem_in;
   logic        add_ff, add_in;
   logic        emit_ff, emit_in;
   logic [54:0] prod_ff, prod_in;
   logic [31:0] count_ff, count_in;
   logic [47:0] volume_ff, volume_in;
   logic [63:0] notional_ff, notional_in;
   logic        ovf_ff, ovf_in;
   rsp_type     rsp_ff, rsp_in;

   logic        first;
   logic        open_eff;
   logic [40:0] rem_eff;
   logic [40:0] rem_next;
   logic [40:0] dec;
   logic        price_ok;
   logic        base_ok;
   logic        pass;
   logic        at_start;
   logic        done_c;
   logic        add_c;
   logic        emit_c;

   logic [31:0] base_count;
   logic [47:0] base_volume;
   logic [63:0] base_notional;
   logic [48:0] volume_wide;
   logic [64:0] notional_wide;

   logic        div_busy;
   logic [63:0] quotient;
   logic [30:0] vwap;

   vwa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (notional_ff),
      .divisor  (volume_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      mode_in        = mode_ff;
      side_in        = side_ff;
      flavor_in      = flavor_ff;
      limit_en_in    = limit_en_ff;
      limit_price_in = limit_price_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      target_in      = target_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WINDOW_MODE:  mode_in        = csr_data[1:0];
            REG_SIDE:         side_in        = csr_data[1:0];
            REG_FLAVOR:       flavor_in      = csr_data[2:0];
            REG_LIMIT_ENABLE: limit_en_in    = csr_data[0];
            REG_LIMIT_PRICE:  limit_price_in = csr_data[30:0];
            REG_START_TIME:   start_in       = csr_data;
            REG_END_TIME:     end_in         = csr_data;
            REG_TARGET:       target_in      = csr_data[39:0];
            default:          mode_in        = mode_ff;
         endcase
      end
   end

   // Filter and window decision for the captured trade.
   always_comb begin
      first    = trade_ff.first_of_run;
      open_eff = first | open_ff;
      rem_eff  = first ? {1'b0, target_ff} : rem_ff;
      at_start = trade_ff.trade_time == start_ff;

      case (side_ff)
         SIDE_BUY:  price_ok = limit_price_ff >= trade_ff.trade_price;
         SIDE_SELL: price_ok = limit_price_ff <= trade_ff.trade_price;
         default:   price_ok = 1'b0;
      endcase
      base_ok = trade_ff.volume_eligible & (~limit_en_ff | price_ok);

      case (flavor_ff)
         FLV_ELIGIBLE: pass = base_ok;
         FLV_REGULAR:  pass = base_ok & trade_ff.avg_px_eligible;
         FLV_EXCHANGE: pass = base_ok & trade_ff.avg_px_eligible &
                              (trade_ff.venue_code != CHAR_OFFEX);
         FLV_BLOCK:    pass = base_ok & trade_ff.avg_px_eligible & trade_ff.is_block;
         FLV_OFFEX:    pass = base_ok & trade_ff.avg_px_eligible &
                              (trade_ff.venue_code == CHAR_OFFEX);
         default:      pass = base_ok;
      endcase

      case (mode_ff)
         MODE_VOLUME:    dec = {17'd0, trade_ff.trade_qty};
         MODE_TICKS_FWD: dec = 41'd1;
         MODE_TICKS_REV: dec = 41'd1;
         default:        dec = 41'd1;
      endcase

      done_c   = 1'b0;
      add_c    = 1'b0;
      rem_next = rem_eff;
      if (mode_ff == MODE_TIME) begin
         if (start_ff <= end_ff) begin
            done_c = trade_ff.trade_time > end_ff;
            add_c  = ~done_c & pass;
         end else if (first) begin
            add_c = at_start & pass;
         end else begin
            done_c = trade_ff.trade_time < end_ff;
            add_c  = ~done_c & pass;
         end
      end else begin
         add_c = pass & (rem_eff != '0) &
                 ~((mode_ff == MODE_TICKS_REV) & first & ~at_start);
         if (add_c) begin
            rem_next = (dec >= rem_eff) ? '0 : rem_eff - dec;
         end
         done_c = rem_next == '0;
      end
      emit_c = open_eff & (done_c | trade_ff.last_of_trades);
   end

   always_comb begin
      trade_in = cmd.capture ? req_data : trade_ff;
      open_in  = open_ff;
      rem_in   = rem_ff;
      add_in   = add_ff;
      emit_in  = emit_ff;
      prod_in  = prod_ff;
      if (cmd.eval) begin
         open_in = open_eff & ~emit_c;
         rem_in  = open_eff ? rem_next : rem_ff;
         add_in  = open_eff & add_c;
         emit_in = emit_c;
         prod_in = 55'(trade_ff.trade_price) * 55'(trade_ff.trade_qty);
      end
   end

   // Accumulation with saturation; a new run starts from zero.
   always_comb begin
      base_count    = first ? '0 : count_ff;
      base_volume   = first ? '0 : volume_ff;
      base_notional = first ? '0 : notional_ff;
      volume_wide   = {1'b0, base_volume} + {25'd0, trade_ff.trade_qty};
      notional_wide = {1'b0, base_notional} + {10'd0, prod_ff};
      count_in      = count_ff;
      volume_in     = volume_ff;
      notional_in   = notional_ff;
      ovf_in        = ovf_ff;
      if (cmd.update) begin
         count_in    = base_count;
         volume_in   = base_volume;
         notional_in = base_notional;
         ovf_in      = ~first & ovf_ff;
         if (add_ff) begin
            count_in    = (base_count == '1) ? base_count : base_count + 1'b1;
            volume_in   = volume_wide[48] ? '1 : volume_wide[47:0];
            notional_in = notional_wide[64] ? '1 : notional_wide[63:0];
            ovf_in      = ovf_in | notional_wide[64];
         end
      end
   end

   always_comb begin
      if (volume_ff == '0) begin
         vwap = '0;
      end else if (quotient[63:31] != '0) begin
         vwap = '1;
      end else begin
         vwap = quotient[30:0];
      end
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.window_count      = count_ff;
         rsp_in.total_volume      = volume_ff;
         rsp_in.vwap_price        = vwap;
         rsp_in.notional_overflow = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_TIME;
         side_ff        <= SIDE_BUY;
         flavor_ff      <= FLV_ELIGIBLE;
         limit_en_ff    <= 1'b0;
         limit_price_ff <= '0;
         start_ff       <= '0;
         end_ff         <= '0;
         target_ff      <= '0;
         open_ff        <= 1'b0;
         rem_ff         <= '0;
         add_ff         <= 1'b0;
         emit_ff        <= 1'b0;
         count_ff       <= '0;
         volume_ff      <= '0;
         notional_ff    <= '0;
         ovf_ff         <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         side_ff        <= side_in;
         flavor_ff      <= flavor_in;
         limit_en_ff    <= limit_en_in;
         limit_price_ff <= limit_price_in;
         start_ff       <= start_in;
         end_ff         <= end_in;
         target_ff      <= target_in;
         open_ff        <= open_in;
         rem_ff         <= rem_in;
         add_ff         <= add_in;
         emit_ff        <= emit_in;
         count_ff       <= count_in;
         volume_ff      <= volume_in;
         notional_ff    <= notional_in;
         ovf_ff         <= ovf_in;
      end
      trade_ff <= trade_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign status.emit     = emit_ff;
   assign status.div_busy = div_busy;
   assign rsp_data        = rsp_ff;

endmodule

>>> design/vwa_controller.sv
// Controller state machine: sequences capture, evaluation, accumulation,
// division and the response handshake. Depends on vwa_pkg.
module vwa_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  vwa_pkg::status_type status,
   output vwa_pkg::cmd_type    cmd
);
   import vwa_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EVAL   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_START  = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_LOAD   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? ST_START : ST_IDLE;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> test/vwap_window_checker.sv
// Window result checker for the VWAP window accumulator testbench. It predicts each
// result from the accepted requests and register writes and compares the responses.
// Depends on vwa_pkg.
`timescale 1ns / 100ps
module vwap_window_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  vwa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  vwa_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [46:0]      csr_data,
   output int               error_count,
   output int               results_owed
);
   import vwa_pkg::*;

   logic [1:0]  mode;
   logic [1:0]  side_sel;
   logic [2:0]  flavor_sel;
   logic        limit_on;
   logic [30:0] limit_px;
   logic [46:0] start_ns;
   logic [46:0] end_ns;
   logic [39:0] target;

   logic [31:0] count_acc;
   logic [47:0] volume_acc;
   logic [63:0] notional_acc;
   logic [40:0] target_left;
   logic        window_live;
   logic        notional_sat;

   rsp_type expected_windows[$];

   function automatic bit trade_passes(input req_type r);
      bit ok;
      ok = r.volume_eligible;
      if (limit_on) begin
         if (side_sel == SIDE_BUY) ok = ok && (limit_px >= r.trade_price);
         else if (side_sel == SIDE_SELL) ok = ok && (limit_px <= r.trade_price);
         else ok = 1'b0;
      end
      case (flavor_sel)
         FLV_REGULAR: ok = ok && r.avg_px_eligible;
         FLV_EXCHANGE: ok = ok && r.avg_px_eligible && (r.venue_code != CHAR_OFFEX);
         FLV_BLOCK: ok = ok && r.avg_px_eligible && r.is_block;
         FLV_OFFEX: ok = ok && r.avg_px_eligible && (r.venue_code == CHAR_OFFEX);
         default: ;
      endcase
      return ok;
   endfunction

   function automatic void accumulate(input req_type r);
      logic [63:0] product;
      logic [48:0] volume_next;
      logic [64:0] notional_next;
      product = 64'(r.trade_price) * 64'(r.trade_qty);
      if (count_acc != '1) count_acc = count_acc + 32'd1;
      volume_next = {1'b0, volume_acc} + 49'(r.trade_qty);
      volume_acc = volume_next[48] ? '1 : volume_next[47:0];
      notional_next = {1'b0, notional_acc} + {1'b0, product};
      if (notional_next[64]) begin
         notional_acc = '1;
         notional_sat = 1'b1;
      end else begin
         notional_acc = notional_next[63:0];
      end
   endfunction

   function automatic void predict_trade(input req_type r);
      bit          ok;
      bit          take;
      bit          closes;
      logic [40:0] decrement;
      logic [63:0] quotient;
      rsp_type     window_result;
      closes = 1'b0;
      if (r.first_of_run) begin
         count_acc    = '0;
         volume_acc   = '0;
         notional_acc = '0;
         notional_sat = 1'b0;
         window_live  = 1'b1;
         target_left  = {1'b0, target};
      end
      if (!window_live) return;
      ok = trade_passes(r);
      if (mode == MODE_TIME) begin
         if (start_ns <= end_ns) begin
            if (r.trade_time > end_ns) closes = 1'b1;
            else if (ok) accumulate(r);
         end else if (r.first_of_run) begin
            if (r.trade_time == start_ns && ok) accumulate(r);
         end else if (r.trade_time < end_ns) begin
            closes = 1'b1;
         end else if (ok) begin
            accumulate(r);
         end
      end else begin
         take = ok && (target_left != '0);
         if (mode == MODE_TICKS_REV && r.first_of_run && r.trade_time != start_ns) take = 1'b0;
         if (take) begin
            decrement = (mode == MODE_VOLUME) ? 41'(r.trade_qty) : 41'd1;
            accumulate(r);
            target_left = (decrement >= target_left) ? 41'd0 : target_left - decrement;
         end
         if (target_left == '0) closes = 1'b1;
      end
      if (closes || r.last_of_trades) begin
         quotient = '0;
         if (volume_acc != '0) quotient = notional_acc / 64'(volume_acc);
         window_result.window_count      = count_acc;
         window_result.total_volume      = volume_acc;
         window_result.vwap_price        = (quotient > 64'h7fff_ffff) ? '1 : quotient[30:0];
         window_result.notional_overflow = notional_sat;
         expected_windows.push_back(window_result);
         window_live = 1'b0;
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count = error_count + 1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode         = '0;
         side_sel     = '0;
         flavor_sel   = '0;
         limit_on     = '0;
         limit_px     = '0;
         start_ns     = '0;
         end_ns       = '0;
         target       = '0;
         count_acc    = '0;
         volume_acc   = '0;
         notional_acc = '0;
         target_left  = '0;
         window_live  = 1'b0;
         notional_sat = 1'b0;
         expected_windows.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_WINDOW_MODE: mode = csr_data[1:0];
               REG_SIDE: side_sel = csr_data[1:0];
               REG_FLAVOR: flavor_sel = csr_data[2:0];
               REG_LIMIT_ENABLE: limit_on = csr_data[0];
               REG_LIMIT_PRICE: limit_px = csr_data[30:0];
               REG_START_TIME: start_ns = csr_data;
               REG_END_TIME: end_ns = csr_data;
               REG_TARGET: target = csr_data[39:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_trade(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_windows.size() == 0) begin
               $error("Response with no window result outstanding: %p", rsp_data);
               error_count = error_count + 1;
            end else begin
               want = expected_windows.pop_front();
               check_field("window_count", 64'(want.window_count),
                           64'(rsp_data.window_count));
               check_field("total_volume", 64'(want.total_volume),
                           64'(rsp_data.total_volume));
               check_field("vwap_price", 64'(want.vwap_price), 64'(rsp_data.vwap_price));
               check_field("notional_overflow", 64'(want.notional_overflow),
                           64'(rsp_data.notional_overflow));
            end
         end
      end
      results_owed <= expected_windows.size();
   end

endmodule

>>> test/vwap_window_accumulator_tb.sv
// Testbench top for the VWAP window accumulator: clock, reset, register setup,
// directed and random trade streams, random stalls, watchdog and the verdict.
// Depends on vwa_pkg, vwap_window_accumulator and vwap_window_checker.
`timescale 1ns / 100ps
module vwap_window_accumulator_tb;
   import vwa_pkg::*;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  side;
      logic [2:0]  flavor;
      logic        limit_on;
      logic [30:0] limit_px;
      logic [46:0] start_ns;
      logic [46:0] end_ns;
      logic [39:0] target;
   } window_setup_type;

   localparam int          STALL_PCT      = 33;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          RANDOM_PHASES  = 7;
   localparam int          PHASE_TRADES   = 45;
   localparam logic [46:0] TIME_MAX       = '1;
   localparam logic [30:0] PRICE_MAX      = '1;
   localparam logic [23:0] QTY_MAX        = '1;
   localparam logic [1:0]  SIDE_OTHER     = 2'd2;
   localparam logic [1:0]  SIDE_OTHER_HI  = 2'd3;
   localparam logic [2:0]  FLV_UNUSED     = 3'd7;
   localparam logic [7:0]  VENUE_A        = "A";
   localparam logic [7:0]  VENUE_C        = "C";
   localparam logic [7:0]  VENUE_N        = "N";

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [46:0] csr_data  = '0;

   int          error_count;
   int          results_owed;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;
   logic [30:0] price_center = 31'd100000;

   vwap_window_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   vwap_window_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < STALL_PCT);
   end

   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic window_setup_type setup_of(input logic [1:0] mode,
                                                 input logic [1:0] side,
                                                 input logic [2:0] flavor,
                                                 input logic limit_on,
                                                 input logic [30:0] limit_px,
                                                 input logic [46:0] start_ns,
                                                 input logic [46:0] end_ns,
                                                 input logic [39:0] target);
      window_setup_type s;
      s.mode     = mode;
      s.side     = side;
      s.flavor   = flavor;
      s.limit_on = limit_on;
      s.limit_px = limit_px;
      s.start_ns = start_ns;
      s.end_ns   = end_ns;
      s.target   = target;
      return s;
   endfunction

   function automatic req_type make_trade(input bit first, input bit last,
                                          input logic [46:0] t, input logic [30:0] px,
                                          input logic [23:0] qty, input bit ve, input bit vw,
                                          input bit blk, input logic [7:0] venue);
      req_type r;
      r.first_of_run    = first;
      r.last_of_trades  = last;
      r.trade_time      = t;
      r.trade_price     = px;
      r.trade_qty       = qty;
      r.volume_eligible = ve;
      r.avg_px_eligible = vw;
      r.is_block        = blk;
      r.venue_code      = venue;
      return r;
   endfunction

   function automatic window_setup_type random_setup();
      window_setup_type s;
      s.mode     = 2'($urandom_range(3));
      s.side     = 2'($urandom_range(3));
      s.flavor   = 3'($urandom_range(7));
      s.limit_on = ($urandom_range(99) < 40);
      case ($urandom_range(9))
         0: s.limit_px = '0;
         1: s.limit_px = '1;
         2: s.limit_px = 31'($urandom);
         default: s.limit_px = price_center + 31'($urandom_range(600)) - 31'd300;
      endcase
      s.start_ns = {1'b0, 46'({$urandom, $urandom})} + 47'd1000000;
      if (s.mode == MODE_TIME) begin
         s.end_ns = $urandom_range(1) ? s.start_ns + 47'($urandom_range(3000))
                                      : s.start_ns - 47'($urandom_range(3000, 1));
      end else begin
         s.end_ns = 47'({$urandom, $urandom});
      end
      case ($urandom_range(9))
         0: s.target = '0;
         1: s.target = '1;
         2: s.target = 40'({$urandom, $urandom});
         default: s.target = (s.mode == MODE_VOLUME) ? 40'($urandom_range(20000, 1))
                                                     : 40'($urandom_range(12, 1));
      endcase
      return s;
   endfunction

   task automatic send_trade(input req_type item);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [46:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic program_window(input window_setup_type s);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      write_reg(REG_WINDOW_MODE, 47'(s.mode));
      write_reg(REG_SIDE, 47'(s.side));
      write_reg(REG_FLAVOR, 47'(s.flavor));
      write_reg(REG_LIMIT_ENABLE, 47'(s.limit_on));
      write_reg(REG_LIMIT_PRICE, 47'(s.limit_px));
      write_reg(REG_START_TIME, s.start_ns);
      write_reg(REG_END_TIME, s.end_ns);
      write_reg(REG_TARGET, 47'(s.target));
      csr_write <= 1'b0;
   endtask

   task automatic run_burst(input window_setup_type s, input int len, input bit broken,
                            input bit close_out);
      logic [46:0] t;
      bit          fwd;
      req_type     r;
      fwd = (s.mode == MODE_TIME) ? (s.start_ns <= s.end_ns) : (s.mode != MODE_TICKS_REV);
      t = s.start_ns;
      if ($urandom_range(99) < 15) begin
         t = fwd ? t + 47'($urandom_range(3, 1)) : t - 47'($urandom_range(3, 1));
      end
      for (int k = 0; k < len; k++) begin
         r.first_of_run    = !broken && (k == 0);
         r.last_of_trades  = (k == len - 1) ? close_out : ($urandom_range(99) < 2);
         r.trade_time      = (broken && $urandom_range(1)) ? 47'({$urandom, $urandom}) : t;
         r.trade_price     = ($urandom_range(99) < 80)
                             ? price_center + 31'($urandom_range(1000)) - 31'd500
                             : 31'($urandom);
         case ($urandom_range(9))
            0: r.trade_qty = '0;
            1: r.trade_qty = 24'($urandom);
            default: r.trade_qty = 24'($urandom_range(2000, 1));
         endcase
         r.volume_eligible = ($urandom_range(99) < 85);
         r.avg_px_eligible = ($urandom_range(99) < 80);
         r.is_block        = $urandom_range(1);
         r.venue_code      = ($urandom_range(99) < 50) ? CHAR_OFFEX : 8'($urandom);
         send_trade(r);
         t = fwd ? t + 47'($urandom_range(400)) : t - 47'($urandom_range(400));
      end
   endtask

   initial begin
      window_setup_type s;
      int               sent;
      int               len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      program_window(setup_of(MODE_TIME, SIDE_BUY, FLV_ELIGIBLE, 1'b0, '0, '0, 47'd1000, '0));
      send_trade(make_trade(1, 0, 0, PRICE_MAX, QTY_MAX, 1, 1, 1, CHAR_OFFEX));
      send_trade(make_trade(0, 0, 500, 0, 0, 0, 0, 0, 8'h00));
      send_trade(make_trade(0, 0, 1000, 1, 1, 1, 0, 0, VENUE_A));
      send_trade(make_trade(0, 0, 1001, 5, 5, 1, 1, 1, VENUE_N));
      send_trade(make_trade(0, 0, 2000, 7, 7, 1, 1, 1, VENUE_N));
      send_trade(make_trade(1, 1, 5, 10, 3, 1, 1, 0, VENUE_N));

      program_window(setup_of(MODE_TIME, SIDE_SELL, FLV_REGULAR, 1'b1, 31'd300, 47'd5000,
                              47'd1000, '0));
      send_trade(make_trade(1, 0, 5000, 400, 10, 1, 1, 0, VENUE_N));
      send_trade(make_trade(0, 0, 4000, 200, 10, 1, 1, 0, VENUE_N));
      send_trade(make_trade(0, 0, 3000, 300, 10, 1, 0, 0, VENUE_N));
      send_trade(make_trade(0, 0, 999, 300, 10, 1, 1, 0, VENUE_N));
      send_trade(make_trade(1, 0, 4999, 500, 10, 1, 1, 0, VENUE_N));
      send_trade(make_trade(0, 1, 2000, 500, 20, 1, 1, 0, VENUE_N));

      program_window(setup_of(MODE_VOLUME, SIDE_BUY, FLV_EXCHANGE, 1'b1, 31'd1000, '0, '0,
                              40'd1000));
      send_trade(make_trade(1, 0, 10, 900, 400, 1, 1, 0, VENUE_A));
      send_trade(make_trade(0, 0, 11, 1100, 400, 1, 1, 0, VENUE_A));
      send_trade(make_trade(0, 0, 12, 900, 400, 1, 1, 0, CHAR_OFFEX));
      send_trade(make_trade(0, 0, 13, 1000, 700, 1, 1, 0, VENUE_A));

      program_window(setup_of(MODE_TICKS_FWD, SIDE_BUY, FLV_BLOCK, 1'b0, '0, '0, '0, 40'd2));
      send_trade(make_trade(1, 0, 20, 100, 5, 1, 1, 1, VENUE_N));
      send_trade(make_trade(0, 0, 21, 100, 5, 1, 1, 0, VENUE_N));
      send_trade(make_trade(0, 0, 22, 200, 5, 1, 1, 1, VENUE_N));

      program_window(setup_of(MODE_TICKS_REV, SIDE_OTHER, FLV_OFFEX, 1'b0, '0, 47'd777, '0,
                              40'd3));
      send_trade(make_trade(1, 0, 778, 100, 1, 1, 1, 0, CHAR_OFFEX));
      send_trade(make_trade(0, 0, 600, 100, 2, 1, 1, 0, CHAR_OFFEX));
      send_trade(make_trade(0, 0, 500, 100, 2, 1, 1, 0, VENUE_C));
      send_trade(make_trade(0, 1, 400, 300, 2, 1, 1, 0, CHAR_OFFEX));

      program_window(setup_of(MODE_TICKS_FWD, SIDE_OTHER_HI, FLV_UNUSED, 1'b1, PRICE_MAX,
                              TIME_MAX, TIME_MAX, '0));
      send_trade(make_trade(1, 0, 30, 100, 1, 1, 1, 1, VENUE_N));
      send_trade(make_trade(1, 1, 31, 100, 1, 1, 1, 1, VENUE_N));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm = (phase == 3) || (phase == 4);
         price_center = 31'($urandom_range(32'h7fff_f000, 1000));
         s = random_setup();
         program_window(s);
         sent = 0;
         while (sent < PHASE_TRADES) begin
            len = $urandom_range(25, 2);
            run_burst(s, len, $urandom_range(99) < 15, $urandom_range(99) < 50);
            sent += len;
         end
         run_burst(s, 1, 1'b1, 1'b1);
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && results_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
